### src/sharpen_3x3_stencil_unit_defines.svh
// assertion macros for the sharpen stencil unit
// expects clk and rst_n in the scope where a macro is used
`ifndef SHARPEN_3X3_STENCIL_UNIT_DEFINES_SVH
`define SHARPEN_3X3_STENCIL_UNIT_DEFINES_SVH

`define SHP3_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sharpen stencil check failed");

`define SHP3_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sharpen stencil check failed");

`endif

### src/shp3_pkg.sv
// shared types and constants of the sharpen stencil unit
// no dependencies
`default_nettype none

package shp3_pkg;

  localparam int STORE_LIMIT = 8192;

  localparam int SAMPLE_W = 8;
  localparam int ROW_W    = 12;
  localparam int BYTE_W   = 13;
  localparam int WIDTH_W  = 12;
  localparam int HEIGHT_W = 13;
  localparam int CHAN_W   = 3;
  localparam int CFG_W    = 13;
  localparam int RBYTES_W = 14;

  localparam logic [HEIGHT_W-1:0] HEIGHT_LIMIT = 13'd4096;

  localparam logic [WIDTH_W-1:0]  RST_WIDTH    = 12'd640;
  localparam logic [HEIGHT_W-1:0] RST_HEIGHT   = 13'd480;
  localparam logic [CHAN_W-1:0]   RST_CHANNELS = 3'd3;

  typedef enum logic [1:0] {
    CFG_WIDTH    = 2'd0,
    CFG_HEIGHT   = 2'd1,
    CFG_CHANNELS = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic has_res;
    logic interior;
    logic last_row;
    logic last_byte;
  } s1_flags_t;

  // widest row in pixels that fits the store for a given channel count
  function automatic logic [RBYTES_W-1:0] pixel_limit(input logic [CHAN_W-1:0] chans);
    logic [RBYTES_W-1:0] lim;
    begin
      unique case (chans)
        3'd1:    lim = 14'd8192;
        3'd2:    lim = 14'd4096;
        3'd3:    lim = 14'd2730;
        default: lim = 14'd2048;
      endcase
      return lim;
    end
  endfunction

endpackage

`default_nettype wire

### src/sharpen_3x3_stencil_unit.sv
// sharpen stencil unit: 3x3 laplacian sharpen over interleaved 8-bit channels
// throughput: one input word per cycle while out_stall is low; on the last row, where each input
//   word yields two result words, the input stalls while the second result word is pending
// reset: synchronous active low; clears counters and pipeline, loads default config
//   the two row stores are not cleared
`default_nettype none
`include "sharpen_3x3_stencil_unit_defines.svh"

module sharpen_3x3_stencil_unit #(
  parameter int MAX_WIDTH    = 2048,
  parameter int MAX_CHANNELS = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [shp3_pkg::CFG_W-1:0]    cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [shp3_pkg::SAMPLE_W-1:0] in_sample,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [shp3_pkg::SAMPLE_W-1:0] out_value,
  output logic      [shp3_pkg::ROW_W-1:0]    out_row,
  output logic      [shp3_pkg::BYTE_W-1:0]   out_byte,
  output logic                               out_frame_done
);

  import shp3_pkg::*;

  localparam int DEPTH_RAW   = MAX_WIDTH * MAX_CHANNELS;
  localparam int STORE_DEPTH = (DEPTH_RAW < STORE_LIMIT) ? DEPTH_RAW : STORE_LIMIT;
  localparam int AW          = $clog2(STORE_DEPTH);

  // configuration
  logic [WIDTH_W-1:0]  width_r,  width_nxt,  width_src;
  logic [HEIGHT_W-1:0] height_r, height_nxt, height_src;
  logic [CHAN_W-1:0]   chan_r,   chan_nxt,   chan_src;

  logic [CHAN_W-1:0]   chan_eff_r,   chan_eff_nxt;
  logic [HEIGHT_W-1:0] height_eff_r, height_eff_nxt;
  logic [RBYTES_W-1:0] row_bytes_r,  row_bytes_nxt;
  logic [RBYTES_W-1:0] pix_lim, pix_eff;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    chan_nxt   = chan_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_WIDTH:    width_nxt  = cfg_data[WIDTH_W-1:0];
        CFG_HEIGHT:   height_nxt = cfg_data[HEIGHT_W-1:0];
        CFG_CHANNELS: chan_nxt   = cfg_data[CHAN_W-1:0];
        default: ;
      endcase
    end
    if (rst_n) begin
      width_src  = width_nxt;
      height_src = height_nxt;
      chan_src   = chan_nxt;
    end else begin
      width_src  = RST_WIDTH;
      height_src = RST_HEIGHT;
      chan_src   = RST_CHANNELS;
    end
  end

  // effective limits follow the written values on the same edge
  always_comb begin
    chan_eff_nxt = chan_src;
    if (chan_src < 3'd1) begin
      chan_eff_nxt = 3'd1;
    end else if (chan_src > CHAN_W'(MAX_CHANNELS)) begin
      chan_eff_nxt = CHAN_W'(MAX_CHANNELS);
    end

    height_eff_nxt = height_src;
    if (height_src < 13'd3) begin
      height_eff_nxt = 13'd3;
    end else if (height_src > HEIGHT_LIMIT) begin
      height_eff_nxt = HEIGHT_LIMIT;
    end

    pix_lim = pixel_limit(chan_eff_nxt);
    if (RBYTES_W'(MAX_WIDTH) < pix_lim) begin
      pix_lim = RBYTES_W'(MAX_WIDTH);
    end
    pix_eff = RBYTES_W'(width_src);
    if (pix_eff < 14'd3) begin
      pix_eff = 14'd3;
    end else if (pix_eff > pix_lim) begin
      pix_eff = pix_lim;
    end
    row_bytes_nxt = pix_eff * RBYTES_W'(chan_eff_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_WIDTH;
      height_r <= RST_HEIGHT;
      chan_r   <= RST_CHANNELS;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      chan_r   <= chan_nxt;
    end
    chan_eff_r   <= chan_eff_nxt;
    height_eff_r <= height_eff_nxt;
    row_bytes_r  <= row_bytes_nxt;
  end

  // handshake
  logic in_accept;
  logic s1_valid_r;
  logic s1_fire;
  logic out_valid_r, pend_valid_r;
  logic out_take, out_room;

  // position counters
  logic [ROW_W-1:0]    row_cnt_r,  row_cnt_nxt;
  logic [BYTE_W-1:0]   byte_cnt_r, byte_cnt_nxt;
  logic                wrap_b;
  logic [ROW_W:0]      row_step, row_inc;
  logic [ROW_W-1:0]    cur_row;
  logic [BYTE_W-1:0]   cur_byte, left_full;
  logic [RBYTES_W-1:0] byte_inc, right_full, chan14;
  s1_flags_t           flags_nxt;
  logic [AW-1:0]       addr_ctr, addr_left, addr_right;

  always_comb begin
    wrap_b   = {1'b0, byte_cnt_r} >= row_bytes_r;
    row_step = wrap_b ? ({1'b0, row_cnt_r} + 13'd1) : {1'b0, row_cnt_r};
    cur_row  = (row_step >= height_eff_r) ? '0 : row_step[ROW_W-1:0];
    cur_byte = wrap_b ? '0 : byte_cnt_r;

    byte_inc = {1'b0, cur_byte} + 14'd1;
    row_inc  = {1'b0, cur_row} + 13'd1;
    row_cnt_nxt  = row_cnt_r;
    byte_cnt_nxt = byte_cnt_r;
    if (in_accept) begin
      if (byte_inc >= row_bytes_r) begin
        byte_cnt_nxt = '0;
        row_cnt_nxt  = (row_inc >= height_eff_r) ? '0 : row_inc[ROW_W-1:0];
      end else begin
        byte_cnt_nxt = byte_inc[BYTE_W-1:0];
        row_cnt_nxt  = cur_row;
      end
    end

    chan14     = RBYTES_W'(chan_eff_r);
    right_full = {1'b0, cur_byte} + chan14;
    left_full  = cur_byte - BYTE_W'(chan_eff_r);

    flags_nxt.has_res   = cur_row != '0;
    flags_nxt.interior  = (cur_row >= 12'd2) && ({1'b0, cur_byte} >= chan14)
                          && (right_full < row_bytes_r);
    flags_nxt.last_row  = {1'b0, cur_row} == (height_eff_r - 13'd1);
    flags_nxt.last_byte = {1'b0, cur_byte} == (row_bytes_r - 14'd1);

    addr_ctr   = cur_byte[AW-1:0];
    addr_right = right_full[AW-1:0];
    addr_left  = left_full[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r  <= '0;
      byte_cnt_r <= '0;
    end else begin
      row_cnt_r  <= row_cnt_nxt;
      byte_cnt_r <= byte_cnt_nxt;
    end
  end

  // stage 1 registers
  logic [SAMPLE_W-1:0] s1_sample_r;
  logic [BYTE_W-1:0]   s1_byte_r;
  logic [ROW_W-1:0]    s1_row_r;
  s1_flags_t           s1_flags_r;
  logic [AW-1:0]       s1_addr_r;

  // store ports
  logic [SAMPLE_W-1:0] rec_ctr_q, rec_right_q, old_left_q, old_up_q;
  logic [SAMPLE_W-1:0] ctr_v, right_v, left_v, up_v;

  // bypass of the write issued on the same edge as the read
  logic                fwd_ctr_r, fwd_right_r, fwd_left_r, fwd_up_r;
  logic [SAMPLE_W-1:0] fwd_rec_r, fwd_old_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
    if (in_accept) begin
      s1_sample_r <= in_sample;
      s1_byte_r   <= cur_byte;
      s1_row_r    <= cur_row;
      s1_flags_r  <= flags_nxt;
      s1_addr_r   <= addr_ctr;
      fwd_ctr_r   <= s1_fire && (addr_ctr == s1_addr_r);
      fwd_right_r <= s1_fire && (addr_right == s1_addr_r);
      fwd_left_r  <= s1_fire && (addr_left == s1_addr_r);
      fwd_up_r    <= s1_fire && (addr_ctr == s1_addr_r);
      fwd_rec_r   <= s1_sample_r;
      fwd_old_r   <= ctr_v;
    end
  end

  assign ctr_v   = fwd_ctr_r   ? fwd_rec_r : rec_ctr_q;
  assign right_v = fwd_right_r ? fwd_rec_r : rec_right_q;
  assign left_v  = fwd_left_r  ? fwd_old_r : old_left_q;
  assign up_v    = fwd_up_r    ? fwd_old_r : old_up_q;

  shp3_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (STORE_DEPTH)
  ) u_recent (
    .clk     (clk),
    .we      (s1_fire),
    .waddr   (s1_addr_r),
    .wdata   (s1_sample_r),
    .re      (in_accept),
    .raddr_a (addr_ctr),
    .raddr_b (addr_right),
    .rdata_a (rec_ctr_q),
    .rdata_b (rec_right_q)
  );

  shp3_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (STORE_DEPTH)
  ) u_older (
    .clk     (clk),
    .we      (s1_fire),
    .waddr   (s1_addr_r),
    .wdata   (ctr_v),
    .re      (in_accept),
    .raddr_a (addr_left),
    .raddr_b (addr_ctr),
    .rdata_a (old_left_q),
    .rdata_b (old_up_q)
  );

  // kernel
  logic [11:0]         pos_sum, neg_sum, acc;
  logic [SAMPLE_W-1:0] sat_v, res_value;

  always_comb begin
    pos_sum = {2'b00, ctr_v, 2'b00} + 12'(ctr_v);
    neg_sum = 12'(left_v) + 12'(right_v) + 12'(up_v) + 12'(s1_sample_r);
    acc     = pos_sum - neg_sum;
    if (acc[11]) begin
      sat_v = '0;
    end else if (acc[10:8] != 3'd0) begin
      sat_v = 8'hFF;
    end else begin
      sat_v = acc[7:0];
    end
    res_value = s1_flags_r.interior ? sat_v : '0;
  end

  // output register with one pending word for the last row
  logic [SAMPLE_W-1:0] out_value_r;
  logic [ROW_W-1:0]    out_row_r,  pend_row_r;
  logic [BYTE_W-1:0]   out_byte_r, pend_byte_r;
  logic                out_frame_done_r, pend_done_r;

  assign out_take  = out_valid_r && !out_stall;
  assign out_room  = !out_valid_r || (out_take && !pend_valid_r);
  assign s1_fire   = s1_valid_r && (!s1_flags_r.has_res || out_room);
  assign in_stall  = s1_valid_r && !s1_fire;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else if (s1_fire && s1_flags_r.has_res) begin
      out_valid_r  <= 1'b1;
      pend_valid_r <= s1_flags_r.last_row;
    end else if (out_take) begin
      out_valid_r  <= pend_valid_r;
      pend_valid_r <= 1'b0;
    end

    if (s1_fire && s1_flags_r.has_res) begin
      out_value_r      <= res_value;
      out_row_r        <= s1_row_r - 12'd1;
      out_byte_r       <= s1_byte_r;
      out_frame_done_r <= 1'b0;
      pend_row_r       <= s1_row_r;
      pend_byte_r      <= s1_byte_r;
      pend_done_r      <= s1_flags_r.last_byte;
    end else if (out_take && pend_valid_r) begin
      out_value_r      <= '0;
      out_row_r        <= pend_row_r;
      out_byte_r       <= pend_byte_r;
      out_frame_done_r <= pend_done_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_value      = out_value_r;
  assign out_row        = out_row_r;
  assign out_byte       = out_byte_r;
  assign out_frame_done = out_frame_done_r;

  `SHP3_ASSERT_NOW(a_pend_has_out, pend_valid_r, out_valid_r)
  `SHP3_ASSERT_NEXT(a_last_row_pair, s1_fire && s1_flags_r.has_res && s1_flags_r.last_row,
                    pend_valid_r && out_valid_r)
  `SHP3_ASSERT_NOW(a_done_is_final, out_valid_r && out_frame_done_r,
                   (out_value_r == 8'd0) && !pend_valid_r)

endmodule

`default_nettype wire

### src/shp3_ram.sv
// generic simple dual-read ram, one write port, registered reads
// no dependencies
`default_nettype none

module shp3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire
